[rtl/ge2d_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ge2d_pkg
// Shared types and constants of the two-dimensional gather-elements engine:
// field widths, configuration register indexes, controller commands and
// status.
// ----------------------------------------------------------------------------
package ge2d_pkg;

  // Default store shape.
  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 64;

  // Field widths.
  localparam int ELEM_W   = 32;
  localparam int INDEX_W  = 32;
  localparam int CFG_W    = 7;
  localparam int CFG_A_W  = 3;
  localparam int IN_TD_W  = ELEM_W + INDEX_W;
  localparam int OUT_TD_W = ((ELEM_W + 1 + 7) / 8) * 8;

  // Configuration register indexes.
  localparam logic [CFG_A_W-1:0] CFG_SOURCE_ROWS = 3'd0;
  localparam logic [CFG_A_W-1:0] CFG_SOURCE_COLS = 3'd1;
  localparam logic [CFG_A_W-1:0] CFG_INDEX_ROWS  = 3'd2;
  localparam logic [CFG_A_W-1:0] CFG_INDEX_COLS  = 3'd3;
  localparam logic [CFG_A_W-1:0] CFG_GATHER_AXIS = 3'd4;

  // Item command codes.
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_GATHER = 1'b1;

  // Gather axis codes.
  localparam logic AXIS_ROWS = 1'b0;
  localparam logic AXIS_COLS = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;      // latch the input item
    logic exec_load;    // write the latched element into the store
    logic exec_gather;  // check bounds, form address, step the walk
    logic rd_en;        // read the store
    logic out_load;     // move the result into the output register
  } ge2d_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_gather;    // latched item is a gather
    logic out_free;     // output register can take a result this cycle
  } ge2d_status_t;

endpackage

[rtl/ge2d_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ge2d_ctrl
// Controller of the gather-elements engine. Sequences one item at a time:
// capture, execute and, for a gather item, store read and result write-back.
// ----------------------------------------------------------------------------
module ge2d_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  ge2d_pkg::ge2d_status_t status,
  output ge2d_pkg::ge2d_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_READ = 4'b0100,
    ST_WB   = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status.is_gather) begin
          cmd.exec_gather = 1'b1;
          state_nxt       = ST_READ;
        end else begin
          cmd.exec_load = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_WB;
      end
      ST_WB: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/ge2d_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ge2d_dp
// Datapath of the gather-elements engine: configuration registers, element
// store, load pointer, index-matrix walk, bounds check, address multiply-add
// and the output register.
// ----------------------------------------------------------------------------
module ge2d_dp #(
  parameter int MAX_ROWS = ge2d_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = ge2d_pkg::MAX_COLS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [ge2d_pkg::CFG_A_W-1:0]   cfg_addr,
  input  logic [ge2d_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_command,
  input  logic [ge2d_pkg::ELEM_W-1:0]    in_element,
  input  logic [ge2d_pkg::INDEX_W-1:0]   in_index,
  input  logic                           out_tready,
  output logic                           out_valid,
  output logic [ge2d_pkg::ELEM_W-1:0]    out_gathered,
  output logic                           out_in_range,
  output logic                           out_last,
  input  ge2d_pkg::ge2d_cmd_t            cmd,
  output ge2d_pkg::ge2d_status_t         status
);

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int RCNT_W = $clog2(MAX_ROWS + 1);
  localparam int CCNT_W = $clog2(MAX_COLS + 1);
  localparam int RIDX_W = $clog2(MAX_ROWS);
  localparam int CIDX_W = $clog2(MAX_COLS);
  localparam int TOT_W  = RCNT_W + CCNT_W;
  localparam int PROD_W = RIDX_W + CCNT_W + 1;

  // Clamp a row count into 1..MAX_ROWS.
  function automatic logic [RCNT_W-1:0] clamp_rows(input logic [ge2d_pkg::CFG_W-1:0] v);
    logic [31:0] ext;
    logic [31:0] lim;
    ext = 32'(v);
    lim = 32'(MAX_ROWS);
    if (ext == 32'd0) begin
      ext = 32'd1;
    end else if (ext > lim) begin
      ext = lim;
    end
    return RCNT_W'(ext);
  endfunction

  // Clamp a column count into 1..MAX_COLS.
  function automatic logic [CCNT_W-1:0] clamp_cols(input logic [ge2d_pkg::CFG_W-1:0] v);
    logic [31:0] ext;
    logic [31:0] lim;
    ext = 32'(v);
    lim = 32'(MAX_COLS);
    if (ext == 32'd0) begin
      ext = 32'd1;
    end else if (ext > lim) begin
      ext = lim;
    end
    return CCNT_W'(ext);
  endfunction

  // Configuration registers.
  logic [ge2d_pkg::CFG_W-1:0] src_rows_r;
  logic [ge2d_pkg::CFG_W-1:0] src_cols_r;
  logic [ge2d_pkg::CFG_W-1:0] idx_rows_r;
  logic [ge2d_pkg::CFG_W-1:0] idx_cols_r;
  logic                       axis_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_rows_r <= ge2d_pkg::CFG_W'(1);
      src_cols_r <= ge2d_pkg::CFG_W'(1);
      idx_rows_r <= ge2d_pkg::CFG_W'(1);
      idx_cols_r <= ge2d_pkg::CFG_W'(1);
      axis_r     <= ge2d_pkg::AXIS_ROWS;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        ge2d_pkg::CFG_SOURCE_ROWS: src_rows_r <= cfg_wdata;
        ge2d_pkg::CFG_SOURCE_COLS: src_cols_r <= cfg_wdata;
        ge2d_pkg::CFG_INDEX_ROWS:  idx_rows_r <= cfg_wdata;
        ge2d_pkg::CFG_INDEX_COLS:  idx_cols_r <= cfg_wdata;
        ge2d_pkg::CFG_GATHER_AXIS: axis_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Effective sizes.
  logic [RCNT_W-1:0] srows;
  logic [CCNT_W-1:0] scols;
  logic [RCNT_W-1:0] irows;
  logic [CCNT_W-1:0] icols;

  assign srows = clamp_rows(src_rows_r);
  assign scols = clamp_cols(src_cols_r);
  assign irows = clamp_rows(idx_rows_r);
  assign icols = clamp_cols(idx_cols_r);

  // Store size, registered; the user must change the sizes only while the block is idle, the block does not enforce it.
  logic [TOT_W-1:0] total_r;

  always_ff @(posedge clk) begin
    total_r <= TOT_W'(srows) * TOT_W'(scols);
  end

  // Latched input item.
  logic                          command_r;
  logic [ge2d_pkg::ELEM_W-1:0]   element_r;
  logic [ge2d_pkg::INDEX_W-1:0]  index_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      command_r <= ge2d_pkg::CMD_LOAD;
    end else if (cmd.capture) begin
      command_r <= in_command;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      element_r <= in_element;
      index_r   <= in_index;
    end
  end

  assign status.is_gather = (command_r == ge2d_pkg::CMD_GATHER);

  // Load pointer: restart at zero if the store shrank below it, and wrap to zero at the end of the store.
  logic [ADDR_W-1:0] load_pos_r;
  logic [ADDR_W-1:0] load_pos_nxt;
  logic [ADDR_W-1:0] wr_addr;
  logic [TOT_W-1:0]  wr_inc;

  always_comb begin
    if (TOT_W'(load_pos_r) >= total_r) begin
      wr_addr = '0;
    end else begin
      wr_addr = load_pos_r;
    end
    wr_inc = TOT_W'(wr_addr) + TOT_W'(1);
    if (wr_inc >= total_r) begin
      load_pos_nxt = '0;
    end else begin
      load_pos_nxt = ADDR_W'(wr_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_pos_r <= '0;
    end else if (cmd.exec_load) begin
      load_pos_r <= load_pos_nxt;
    end
  end

  // Index-matrix walk.
  logic [RIDX_W-1:0] out_row_r;
  logic [CIDX_W-1:0] out_col_r;
  logic [RIDX_W-1:0] out_row_nxt;
  logic [CIDX_W-1:0] out_col_nxt;
  logic [RCNT_W-1:0] row_inc;
  logic [CCNT_W-1:0] col_inc;
  logic              last_now;

  always_comb begin
    row_inc     = RCNT_W'(out_row_r) + RCNT_W'(1);
    col_inc     = CCNT_W'(out_col_r) + CCNT_W'(1);
    out_row_nxt = out_row_r;
    out_col_nxt = CIDX_W'(col_inc);
    if (col_inc >= icols) begin
      out_col_nxt = '0;
      if (row_inc >= irows) begin
        out_row_nxt = '0;
      end else begin
        out_row_nxt = RIDX_W'(row_inc);
      end
    end
    last_now = (RCNT_W'(out_row_r) == irows - RCNT_W'(1)) &&
               (CCNT_W'(out_col_r) == icols - CCNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_row_r <= '0;
      out_col_r <= '0;
    end else if (cmd.exec_gather) begin
      out_row_r <= out_row_nxt;
      out_col_r <= out_col_nxt;
    end
  end

  // Bounds check and address multiply-add.
  logic              idx_neg;
  logic              ok_now;
  logic [RIDX_W-1:0] row_sel;
  logic [CIDX_W-1:0] col_sel;
  logic [PROD_W-1:0] addr_full;

  always_comb begin
    idx_neg = index_r[ge2d_pkg::INDEX_W-1];
    if (axis_r == ge2d_pkg::AXIS_ROWS) begin
      row_sel = index_r[RIDX_W-1:0];
      col_sel = out_col_r;
      ok_now  = !idx_neg && (index_r < ge2d_pkg::INDEX_W'(srows)) &&
                (CCNT_W'(out_col_r) < scols);
    end else begin
      row_sel = out_row_r;
      col_sel = index_r[CIDX_W-1:0];
      ok_now  = !idx_neg && (index_r < ge2d_pkg::INDEX_W'(scols)) &&
                (RCNT_W'(out_row_r) < srows);
    end
    addr_full = PROD_W'(row_sel) * PROD_W'(scols) + PROD_W'(col_sel);
  end

  logic [ADDR_W-1:0] rd_addr_r;
  logic              ok_r;
  logic              last_r;

  always_ff @(posedge clk) begin
    if (cmd.exec_gather) begin
      rd_addr_r <= ADDR_W'(addr_full);
      ok_r      <= ok_now;
      last_r    <= last_now;
    end
  end

  // Element store, one write port and one registered read port.
  logic [ge2d_pkg::ELEM_W-1:0] store_mem [DEPTH];
  logic [ge2d_pkg::ELEM_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (cmd.exec_load) begin
      store_mem[wr_addr] <= element_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en && ok_r) begin
      rd_data_r <= store_mem[rd_addr_r];
    end
  end

  // Output register; it frees up in the cycle its result transfers.
  logic                        out_valid_r;
  logic [ge2d_pkg::ELEM_W-1:0] out_data_r;
  logic                        out_ok_r;
  logic                        out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= ok_r ? rd_data_r : '0;
      out_ok_r   <= ok_r;
      out_last_r <= last_r;
    end
  end

  assign status.out_free = !out_valid_r || out_tready;
  assign out_valid       = out_valid_r;
  assign out_gathered    = out_data_r;
  assign out_in_range    = out_ok_r;
  assign out_last        = out_last_r;

endmodule

[rtl/gather_elements_2d.sv]
`timescale 1ns / 1ps
// Sequence: a gather item passes the capture, execute, registered store read and
// write-back states before its result is valid; a load item is written into the
// store in the execute state after capture. A new item is accepted only once the
// last one is through, and a gather waits in write-back while the output is full.
// Reset: synchronous, active low; clears the controller, pointers and sizes.
// The element store is not cleared; an entry must be loaded before it is read.
// ----------------------------------------------------------------------------
// gather_elements_2d
// Rank-2 gather-elements engine. Load items fill the data matrix row-major;
// gather items walk the index matrix and return the addressed element.
// ----------------------------------------------------------------------------
module gather_elements_2d #(
  parameter int MAX_ROWS = ge2d_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = ge2d_pkg::MAX_COLS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration write port.
  input  logic                            cfg_wr_en,
  input  logic [ge2d_pkg::CFG_A_W-1:0]    cfg_addr,
  input  logic [ge2d_pkg::CFG_W-1:0]      cfg_wdata,
  // Input stream.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ge2d_pkg::IN_TD_W-1:0]    in_tdata,   // element_bits, gather_index
  input  logic                            in_tuser,   // command
  // Result stream.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ge2d_pkg::OUT_TD_W-1:0]   out_tdata,  // gathered_bits, index_in_range
  output logic                            out_tlast   // last_element
);

  ge2d_pkg::ge2d_cmd_t    cmd;
  ge2d_pkg::ge2d_status_t status;

  logic [ge2d_pkg::ELEM_W-1:0] gathered;
  logic                        in_range;

  ge2d_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  ge2d_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .in_command   (in_tuser),
    .in_element   (in_tdata[ge2d_pkg::ELEM_W-1:0]),
    .in_index     (in_tdata[ge2d_pkg::IN_TD_W-1:ge2d_pkg::ELEM_W]),
    .out_tready   (out_tready),
    .out_valid    (out_tvalid),
    .out_gathered (gathered),
    .out_in_range (in_range),
    .out_last     (out_tlast),
    .cmd          (cmd),
    .status       (status)
  );

  // Pack the result fields, zero padded to whole bytes.
  assign out_tdata = ge2d_pkg::OUT_TD_W'({in_range, gathered});

endmodule
